// ===== hw/rtl/kmerdd_pkg.sv =====
`timescale 1ns / 1ps

package kmerdd_pkg;

    localparam int MAX_BASES_DEF = 32;
    localparam int OFIFO_DEPTH   = 4;

    localparam logic [5:0] SEQ_LEN_RST = 6'd20;
    localparam logic [5:0] POS_SAT     = 6'd63;

    localparam logic [7:0] CHAR_NL = 8'd10;
    localparam logic [7:0] CHAR_A  = 8'h41;
    localparam logic [7:0] CHAR_C  = 8'h43;
    localparam logic [7:0] CHAR_G  = 8'h47;
    localparam logic [7:0] CHAR_T  = 8'h54;

    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;

    localparam logic STATUS_RUN = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_stream;
    } t_in_word;

    typedef struct packed {
        logic [63:0] packed_signature;
        logic [31:0] occurrence_count;
        logic [31:0] site_id;
        logic        status;
        logic        last_of_run;
    } t_out_word;

    typedef struct packed {
        logic wr_first;
        logic wr_second;
    } t_push_ctl;

    // anything that is not a known base letter packs as A
    function automatic logic [1:0] base_code(input logic [7:0] b);
        logic [1:0] c;
        case (b)
            CHAR_C:  c = CODE_C;
            CHAR_G:  c = CODE_G;
            CHAR_T:  c = CODE_T;
            CHAR_A:  c = CODE_A;
            default: c = CODE_A;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/kmerdd_core.sv =====
`timescale 1ns / 1ps

module kmerdd_core #(
    parameter int MAX_BASES = kmerdd_pkg::MAX_BASES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  kmerdd_pkg::t_in_word  i_in_word,
    input  logic                  i_cfg_we,
    input  logic [5:0]            i_cfg_wdata,
    input  logic                  i_room,
    output kmerdd_pkg::t_push_ctl o_push,
    output kmerdd_pkg::t_out_word o_res0,
    output kmerdd_pkg::t_out_word o_res1
);
    import kmerdd_pkg::*;

    localparam int IDX_W = (MAX_BASES > 1) ? $clog2(MAX_BASES) : 1;
    localparam logic [5:0] MAX_LEN = 6'(MAX_BASES);

    logic        r_in_valid;
    t_in_word    r_in_word;
    logic [5:0]  r_seq_len;

    logic [7:0]  r_cur_line  [MAX_BASES];
    logic [7:0]  r_prev_line [MAX_BASES];

    logic [63:0] r_line_sig, n_line_sig;
    logic [63:0] r_run_sig, n_run_sig;
    logic [31:0] r_run_count, n_run_count;
    logic [31:0] r_next_id, n_next_id;
    logic [5:0]  r_base_pos, n_base_pos;
    logic        r_differs, n_differs;
    logic        r_run_open, n_run_open;

    logic            fire;
    logic            is_nl;
    logic            in_range;
    logic            len_ok;
    logic [IDX_W-1:0] pos_idx;
    logic [5:0]      eff_len;
    logic [1:0]      k;
    t_out_word       res [2];

    assign fire       = r_in_valid && i_room;
    assign o_in_ready = i_rst_n && (!r_in_valid || fire);
    assign is_nl      = (r_in_word.text_byte == CHAR_NL);
    assign in_range   = (r_base_pos < MAX_LEN);
    assign pos_idx    = r_base_pos[IDX_W-1:0];

    always_comb begin
        if (r_seq_len == 6'd0) begin
            eff_len = 6'd1;
        end else if (r_seq_len > MAX_LEN) begin
            eff_len = MAX_LEN;
        end else begin
            eff_len = r_seq_len;
        end
    end

    assign len_ok = (r_base_pos == eff_len);

    always_comb begin
        n_line_sig  = r_line_sig;
        n_run_sig   = r_run_sig;
        n_run_count = r_run_count;
        n_next_id   = r_next_id;
        n_base_pos  = r_base_pos;
        n_differs   = r_differs;
        n_run_open  = r_run_open;
        k           = 2'd0;
        res[0]      = '0;
        res[1]      = '0;

        if (!is_nl) begin
            if (in_range) begin
                n_line_sig[{pos_idx, 1'b0} +: 2] = base_code(r_in_word.text_byte);
                if (r_prev_line[pos_idx] != r_in_word.text_byte) begin
                    n_differs = 1'b1;
                end
            end
            if (r_base_pos < POS_SAT) begin
                n_base_pos = r_base_pos + 6'd1;
            end
        end else begin
            if (!len_ok) begin
                res[0].status = STATUS_ERR;
                k = 2'd1;
            end else if (r_run_open && !r_differs) begin
                if (r_run_count != '1) begin
                    n_run_count = r_run_count + 32'd1;
                end
            end else begin
                // a different line closes the old run first
                if (r_run_open) begin
                    res[0] = '{r_run_sig, r_run_count, r_next_id, STATUS_RUN, 1'b0};
                    k = 2'd1;
                    n_next_id = r_next_id + 32'd1;
                end
                n_run_sig   = r_line_sig;
                n_run_count = 32'd1;
                n_run_open  = 1'b1;
            end

            if (r_in_word.end_of_stream && n_run_open) begin
                res[k[0]] = '{n_run_sig, n_run_count, n_next_id, STATUS_RUN, 1'b0};
                k = k + 2'd1;
                n_next_id  = n_next_id + 32'd1;
                n_run_open = 1'b0;
            end

            case (k)
                2'd1:    res[0].last_of_run = 1'b1;
                2'd2:    res[1].last_of_run = 1'b1;
                default: ;
            endcase

            n_base_pos = '0;
            n_line_sig = '0;
            n_differs  = 1'b0;
        end
    end

    assign o_push.wr_first  = fire && (k != 2'd0);
    assign o_push.wr_second = fire && (k == 2'd2);
    assign o_res0 = res[0];
    assign o_res1 = res[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_seq_len   <= SEQ_LEN_RST;
            r_line_sig  <= '0;
            r_run_sig   <= '0;
            r_run_count <= '0;
            r_next_id   <= '0;
            r_base_pos  <= '0;
            r_differs   <= 1'b0;
            r_run_open  <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (i_cfg_we) begin
                r_seq_len <= i_cfg_wdata;
            end
            if (fire) begin
                r_line_sig  <= n_line_sig;
                r_run_sig   <= n_run_sig;
                r_run_count <= n_run_count;
                r_next_id   <= n_next_id;
                r_base_pos  <= n_base_pos;
                r_differs   <= n_differs;
                r_run_open  <= n_run_open;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    // line being received; cleared at reset so short history compares as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_BASES; i++) begin
                r_cur_line[i] <= '0;
            end
        end else if (fire && !is_nl && in_range) begin
            r_cur_line[pos_idx] <= r_in_word.text_byte;
        end
    end

    // only a line of the right length becomes the compare line
    always_ff @(posedge i_clk) begin
        if (fire && is_nl && len_ok) begin
            for (int i = 0; i < MAX_BASES; i++) begin
                r_prev_line[i] <= r_cur_line[i];
            end
        end
    end

`ifndef SYNTHESIS
    a_nl_clears_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && is_nl) |=> (r_base_pos == 6'd0 && !r_differs))
        else $error("line position not cleared after newline");

    a_open_run_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_open |-> (r_run_count != 32'd0))
        else $error("open run with zero count");

    a_err_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.wr_first && o_res0.status == STATUS_ERR) |->
            (o_res0.occurrence_count == 32'd0 && o_res0.packed_signature == 64'd0))
        else $error("error result carries run data");
`endif

endmodule

// ===== hw/rtl/kmerdd_fifo.sv =====
`timescale 1ns / 1ps

module kmerdd_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  kmerdd_pkg::t_push_ctl i_push,
    input  kmerdd_pkg::t_out_word i_res0,
    input  kmerdd_pkg::t_out_word i_res1,
    output logic                  o_room,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output kmerdd_pkg::t_out_word o_out_word
);
    import kmerdd_pkg::*;

    localparam int PTR_W = $clog2(OFIFO_DEPTH);
    localparam int CNT_W = $clog2(OFIFO_DEPTH + 1);

    t_out_word        r_mem [OFIFO_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             pop;
    logic [PTR_W-1:0] wptr_nxt;

    // room for the two results that one newline word can cause
    assign o_room      = (r_count <= CNT_W'(OFIFO_DEPTH - 2));
    assign o_out_valid = (r_count != '0);
    assign o_out_word  = r_mem[r_rptr];
    assign pop         = o_out_valid && i_out_ready;
    assign wptr_nxt    = r_wptr + PTR_W'(1);

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push.wr_second) begin
            n_wptr  = r_wptr + PTR_W'(2);
            n_count = n_count + CNT_W'(2);
        end else if (i_push.wr_first) begin
            n_wptr  = wptr_nxt;
            n_count = n_count + CNT_W'(1);
        end
        if (pop) begin
            n_rptr  = r_rptr + PTR_W'(1);
            n_count = n_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.wr_first) begin
            r_mem[r_wptr] <= i_res0;
        end
        if (i_push.wr_second) begin
            r_mem[wptr_nxt] <= i_res1;
        end
    end

`ifndef SYNTHESIS
    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.wr_second |-> i_push.wr_first)
        else $error("second result pushed without first");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.wr_first |-> o_room)
        else $error("push into result queue without room");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(OFIFO_DEPTH))
        else $error("result queue overflow");
`endif

endmodule

// ===== hw/rtl/dna_kmer_pack_dedup_unit.sv =====
`timescale 1ns / 1ps

// a newline word passes the input register and may write two results into the result queue
// throughput: one text word per cycle unless held back; results leave one per cycle if taken
// input is held back in reset or when the four-entry result queue lacks two free slots
// reset: synchronous, active low; clears control state and the open run, length returns to 20
// the compare line store has no reset; its compare result only matters once a run is open

module dna_kmer_pack_dedup_unit #(
    parameter int MAX_BASES = kmerdd_pkg::MAX_BASES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  kmerdd_pkg::t_in_word  i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output kmerdd_pkg::t_out_word o_out_word,
    input  logic                  i_cfg_we,
    input  logic [5:0]            i_cfg_wdata
);
    import kmerdd_pkg::*;

    t_push_ctl push;
    t_out_word res0;
    t_out_word res1;
    logic      room;

    kmerdd_core #(
        .MAX_BASES (MAX_BASES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_room      (room),
        .o_push      (push),
        .o_res0      (res0),
        .o_res1      (res1)
    );

    kmerdd_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_res0      (res0),
        .i_res1      (res1),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule
